// ===== src/crsp_pkg.sv =====
// ----------------------------------------------------------------------------
// crsp_pkg
// Shared types, character codes and helpers of the coordinate record parser.
// ----------------------------------------------------------------------------
package crsp_pkg;

	typedef logic [7:0]  char_t;
	typedef logic [15:0] mag_t;

	// Characters that steer the parser
	localparam char_t CH_COLON = 8'h3A;  // ':'
	localparam char_t CH_BANG  = 8'h21;  // '!'
	localparam char_t CH_UP    = 8'h5E;  // '^'
	localparam char_t CH_DOWN  = 8'h76;  // 'v'
	localparam char_t CH_MINUS = 8'h2D;  // '-'
	localparam char_t CH_ZERO  = 8'h30;  // '0'
	localparam char_t CH_NINE  = 8'h39;  // '9'
	localparam char_t CH_O_UP  = 8'h4F;  // 'O'
	localparam char_t CH_L_UP  = 8'h4C;  // 'L'
	localparam char_t CH_DOT   = 8'h2E;  // '.'
	localparam char_t CH_C_LO  = 8'h63;  // 'c'
	localparam char_t CH_C_UP  = 8'h43;  // 'C'

	// Largest magnitude kept: one past the positive limit, for -32768
	localparam mag_t MAG_LIMIT = 16'h8000;
	localparam mag_t POS_LIMIT = 16'h7FFF;

	localparam logic [7:0] SEG_MAX = 8'h7F;
	localparam logic [7:0] SEG_MIN = 8'h80;

	// Result kinds
	localparam logic KIND_RECORD = 1'b0;
	localparam logic KIND_INFO   = 1'b1;

	// Turn magnitude and sign into the saturated 16-bit value
	function automatic logic signed [15:0] number_value(input mag_t mag, input logic minus);
		logic signed [15:0] val;
		if (minus) begin
			val = 16'(16'h0000 - mag);
		end else if (mag > POS_LIMIT) begin
			val = POS_LIMIT;
		end else begin
			val = mag;
		end
		return val;
	endfunction

	// Characters passed on as info items
	function automatic logic is_info_char(input char_t c);
		return (c == CH_O_UP) || (c == CH_L_UP) || (c == CH_DOT) ||
			(c == CH_C_LO) || (c == CH_C_UP);
	endfunction

endpackage

// ===== src/coordinate_record_stream_parser.sv =====
// ----------------------------------------------------------------------------
// coordinate_record_stream_parser
// Parses a x:y!info byte stream into coordinate records and info characters.
// ----------------------------------------------------------------------------
// One byte is taken per cycle with no bubbles: the byte is registered in the
// input stage, and the parser state and the result register are updated
// from it once the output register is free. A byte that
// yields no result still moves through the same stage. Throughput drops only
// when result_ready is held low while a result waits in the output register.
module coordinate_record_stream_parser #(
	parameter int INFO_MAX = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               byte_valid,
	output logic               byte_ready,
	input  logic [7:0]         in_byte,
	output logic               result_valid,
	input  logic               result_ready,
	output logic               kind,
	output logic signed [15:0] x_value,
	output logic signed [15:0] y_value,
	output logic signed [7:0]  segment_number,
	output logic [7:0]         info_char,
	output logic [1:0]         info_pos
);

	localparam int CNT_W = $clog2(INFO_MAX + 1);

	// Input stage
	logic                 valid_s1;
	crsp_pkg::char_t      byte_s1;

	// Parser state
	crsp_pkg::mag_t       magnitude_q;
	logic                 minus_seen_q;
	logic                 started_q;
	logic                 closed_q;
	logic signed [15:0]   x_latch_q;
	logic                 record_open_q;
	logic [CNT_W-1:0]     info_count_q;
	logic [7:0]           segment_q;

	// Decode
	logic                 advance;
	logic                 is_digit;
	logic [19:0]          mag_next_w;
	crsp_pkg::mag_t       mag_next;
	logic signed [15:0]   num_val;
	logic                 emit;
	logic                 emit_kind;

	assign advance    = valid_s1 && (!result_valid || result_ready);
	assign byte_ready = !valid_s1 || advance;

	assign is_digit   = (byte_s1 >= crsp_pkg::CH_ZERO) && (byte_s1 <= crsp_pkg::CH_NINE);
	assign mag_next_w = ({4'b0, magnitude_q} << 3) + ({4'b0, magnitude_q} << 1) +
		20'(byte_s1 - crsp_pkg::CH_ZERO);
	assign mag_next   = (mag_next_w > 20'(crsp_pkg::MAG_LIMIT)) ? crsp_pkg::MAG_LIMIT :
		mag_next_w[15:0];
	assign num_val    = crsp_pkg::number_value(magnitude_q, minus_seen_q);

	// Decide whether this byte produces a result and which kind
	always_comb begin
		emit      = 1'b0;
		emit_kind = crsp_pkg::KIND_RECORD;
		if (byte_s1 == crsp_pkg::CH_BANG) begin
			emit = record_open_q;
		end else if (crsp_pkg::is_info_char(byte_s1)) begin
			emit      = record_open_q && (info_count_q < CNT_W'(INFO_MAX));
			emit_kind = crsp_pkg::KIND_INFO;
		end
	end

	// Capture the incoming byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ready) begin
			valid_s1 <= byte_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ready && byte_valid) begin
			byte_s1 <= in_byte;
		end
	end

	// Update parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magnitude_q   <= '0;
			minus_seen_q  <= 1'b0;
			started_q     <= 1'b0;
			closed_q      <= 1'b0;
			x_latch_q     <= '0;
			record_open_q <= 1'b0;
			info_count_q  <= '0;
			segment_q     <= '0;
		end else if (advance) begin
			priority if (is_digit) begin
				if (!closed_q) begin
					magnitude_q <= mag_next;
					started_q   <= 1'b1;
				end
			end else if (byte_s1 == crsp_pkg::CH_MINUS) begin
				if (!started_q && !minus_seen_q && !closed_q) begin
					minus_seen_q <= 1'b1;
				end else begin
					closed_q <= 1'b1;
				end
			end else if (byte_s1 == crsp_pkg::CH_COLON) begin
				x_latch_q     <= num_val;
				magnitude_q   <= '0;
				minus_seen_q  <= 1'b0;
				started_q     <= 1'b0;
				closed_q      <= 1'b0;
				record_open_q <= 1'b1;
			end else if (byte_s1 == crsp_pkg::CH_BANG) begin
				magnitude_q  <= '0;
				minus_seen_q <= 1'b0;
				started_q    <= 1'b0;
				closed_q     <= 1'b0;
				info_count_q <= '0;
			end else if (byte_s1 == crsp_pkg::CH_UP) begin
				if (segment_q != crsp_pkg::SEG_MAX) begin
					segment_q <= segment_q + 8'd1;
				end
			end else if (byte_s1 == crsp_pkg::CH_DOWN) begin
				if (segment_q != crsp_pkg::SEG_MIN) begin
					segment_q <= segment_q - 8'd1;
				end
			end else if (emit) begin
				info_count_q <= info_count_q + CNT_W'(1);
			end else begin
				// Leave the state alone for any other byte
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= emit;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			kind <= emit_kind;
			if (emit_kind == crsp_pkg::KIND_RECORD) begin
				x_value        <= x_latch_q;
				y_value        <= num_val;
				segment_number <= segment_q;
				info_char      <= '0;
				info_pos       <= '0;
			end else begin
				x_value        <= '0;
				y_value        <= '0;
				segment_number <= '0;
				info_char      <= byte_s1;
				info_pos       <= 2'(info_count_q);
			end
		end
	end

`ifndef SYNTH
	// A record result never carries info fields
	a_record_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == crsp_pkg::KIND_RECORD) |-> (info_char == 8'd0 && info_pos == 2'd0))
		else $error("record result carries info fields");

	// An info result never carries coordinates
	a_info_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && kind == crsp_pkg::KIND_INFO) |->
		(x_value == 16'sd0 && y_value == 16'sd0 && segment_number == 8'sd0))
		else $error("info result carries coordinates");

	// Info count stays within its limit
	a_info_limit: assert property (@(posedge clk) disable iff (!arst_n)
		info_count_q <= CNT_W'(INFO_MAX))
		else $error("info count beyond limit");

	// Nothing is emitted before the first colon
	a_open_first: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |-> record_open_q)
		else $error("result before record opened");

	// A waiting result is never overwritten
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result_ready) |-> !advance)
		else $error("pending result overwritten");
`endif

endmodule

// ===== test/coordinate_record_stream_parser_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// coordinate_record_stream_parser_tb
// Self-checking bench for the x:y!info byte stream parser.
// ----------------------------------------------------------------------------
// A short directed string covers saturation, close before the first colon,
// dropped and limited info characters and repeated close. Random records
// with random numbers, info tails, segment runs and noise bytes follow. A
// scoreboard predicts every result from the accepted bytes and compares the
// results in order. The sender works in bursts and the receiver stalls on a
// rotating pattern.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic               kind;
	logic signed [15:0] x;
	logic signed [15:0] y;
	logic signed [7:0]  seg;
	logic [7:0]         ichar;
	logic [1:0]         ipos;
} parse_result_t;

class parser_scoreboard;
	localparam int INFO_LIMIT = 4;

	parse_result_t      pending[$];
	int unsigned        errors;
	int                 acc_mag;
	bit                 neg_sign;
	bit                 has_digit;
	bit                 num_ended;
	bit                 colon_seen;
	logic signed [15:0] held_x;
	int                 info_idx;
	logic signed [7:0]  seg_ctr;

	function new();
		clear_number();
		errors = 0;
		colon_seen = 0;
		held_x = '0;
		info_idx = 0;
		seg_ctr = '0;
	endfunction

	function void clear_number();
		acc_mag = 0;
		neg_sign = 0;
		has_digit = 0;
		num_ended = 0;
	endfunction

	// Saturate the accumulated number to 16 bits
	function logic signed [15:0] current_number();
		if (neg_sign)
			return 16'(0 - acc_mag);
		if (acc_mag > 32767)
			return 16'sh7FFF;
		return 16'(acc_mag);
	endfunction

	function void report(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endfunction

	// Advance the parser state for one accepted item, queue any result
	function void note_byte(crsp_pkg::char_t c);
		parse_result_t r;
		r = '0;
		if (c >= crsp_pkg::CH_ZERO && c <= crsp_pkg::CH_NINE) begin
			if (!num_ended) begin
				acc_mag = acc_mag * 10 + (int'(c) - int'(crsp_pkg::CH_ZERO));
				if (acc_mag > 32768)
					acc_mag = 32768;
				has_digit = 1;
			end
		end else if (c == crsp_pkg::CH_MINUS) begin
			if (!has_digit && !neg_sign && !num_ended)
				neg_sign = 1;
			else
				num_ended = 1;
		end else if (c == crsp_pkg::CH_COLON) begin
			held_x = current_number();
			clear_number();
			colon_seen = 1;
		end else if (c == crsp_pkg::CH_BANG) begin
			r.y = current_number();
			clear_number();
			info_idx = 0;
			if (colon_seen) begin
				r.kind = crsp_pkg::KIND_RECORD;
				r.x = held_x;
				r.seg = seg_ctr;
				pending.push_back(r);
			end
		end else if (c == crsp_pkg::CH_UP) begin
			if (seg_ctr != crsp_pkg::SEG_MAX)
				seg_ctr = seg_ctr + 8'sd1;
		end else if (c == crsp_pkg::CH_DOWN) begin
			if (seg_ctr != crsp_pkg::SEG_MIN)
				seg_ctr = seg_ctr - 8'sd1;
		end else if (c == crsp_pkg::CH_O_UP || c == crsp_pkg::CH_L_UP ||
			c == crsp_pkg::CH_DOT || c == crsp_pkg::CH_C_LO || c == crsp_pkg::CH_C_UP) begin
			if (colon_seen && info_idx < INFO_LIMIT) begin
				r.kind = crsp_pkg::KIND_INFO;
				r.ichar = c;
				r.ipos = 2'(info_idx);
				pending.push_back(r);
				info_idx++;
			end
		end
	endfunction

	// Compare one result with the oldest prediction
	function void check_result(parse_result_t got);
		parse_result_t want;
		if (pending.size() == 0) begin
			report($sformatf("result with nothing pending, kind %0d", got.kind));
			return;
		end
		want = pending.pop_front();
		if (got.kind !== want.kind)
			report($sformatf("kind %0d, want %0d", got.kind, want.kind));
		if (got.x !== want.x)
			report($sformatf("x_value %0d, want %0d", got.x, want.x));
		if (got.y !== want.y)
			report($sformatf("y_value %0d, want %0d", got.y, want.y));
		if (got.seg !== want.seg)
			report($sformatf("segment_number %0d, want %0d", got.seg, want.seg));
		if (got.ichar !== want.ichar)
			report($sformatf("info_char %02h, want %02h", got.ichar, want.ichar));
		if (got.ipos !== want.ipos)
			report($sformatf("info_pos %0d, want %0d", got.ipos, want.ipos));
	endfunction
endclass

module coordinate_record_stream_parser_tb;

	localparam int INFO_MAX    = 4;
	localparam int ITEM_TARGET = 1550;
	localparam int CYCLE_LIMIT = 500000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               byte_valid = 1'b0;
	logic               byte_ready;
	logic [7:0]         in_byte = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	logic               kind;
	logic signed [15:0] x_value;
	logic signed [15:0] y_value;
	logic signed [7:0]  segment_number;
	logic [7:0]         info_char;
	logic [1:0]         info_pos;

	parser_scoreboard sb;
	crsp_pkg::char_t  stim_q[$];
	parse_result_t    observed;
	int               active_items = 0;
	int               burst_left = 0;
	int               calm_bursts = 0;
	int unsigned      cycle_count = 0;
	logic [15:0]      rx_pattern = '1;
	logic [7:0]       rx_tick = '0;
	crsp_pkg::char_t  info_set[5] = '{crsp_pkg::CH_O_UP, crsp_pkg::CH_L_UP,
		crsp_pkg::CH_DOT, crsp_pkg::CH_C_LO, crsp_pkg::CH_C_UP};
	string            edge_nums[8] = '{"0", "32767", "32768", "-32768", "-32769",
		"99999", "-0", "-99999"};

	coordinate_record_stream_parser #(
		.INFO_MAX(INFO_MAX)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.byte_valid(byte_valid),
		.byte_ready(byte_ready),
		.in_byte(in_byte),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.kind(kind),
		.x_value(x_value),
		.y_value(y_value),
		.segment_number(segment_number),
		.info_char(info_char),
		.info_pos(info_pos)
	);

	always #1 clk = ~clk;

	// Stop a hung run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("coordinate_record_stream_parser_tb NOT OK");
			$finish;
		end
	end

	// Stall the result side on a rotating pattern, reshuffled when rx_tick[5:0] wraps to zero
	always @(posedge clk) begin
		rx_tick <= rx_tick + 8'd1;
		if (rx_tick[5:0] == 6'd0) begin
			case ($urandom_range(0, 2))
				0: rx_pattern <= '1;
				1: rx_pattern <= 16'($urandom) | 16'h0101;
				default: rx_pattern <= 16'h0001 << $urandom_range(0, 15);
			endcase
		end
		result_ready <= rx_pattern[rx_tick[3:0]];
	end

	// Check each accepted result
	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			observed = '{kind, x_value, y_value, segment_number, info_char, info_pos};
			sb.check_result(observed);
		end
	end

	// Offer one item, idling between bursts, and hold it until accepted
	task automatic send_char(input crsp_pkg::char_t c);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (calm_bursts > 0) begin
				calm_bursts--;
				gap = 0;
			end else begin
				if ($urandom_range(0, 7) == 0)
					calm_bursts = $urandom_range(3, 10);
				gap = $urandom_range(0, 6);
			end
			if (gap > 0) begin
				byte_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		byte_valid <= 1'b1;
		in_byte <= c;
		do @(posedge clk); while (!byte_ready);
		sb.note_byte(c);
		if ((c >= crsp_pkg::CH_ZERO && c <= crsp_pkg::CH_NINE) ||
			c == crsp_pkg::CH_MINUS || c == crsp_pkg::CH_COLON ||
			c == crsp_pkg::CH_BANG || c == crsp_pkg::CH_UP || c == crsp_pkg::CH_DOWN ||
			c == crsp_pkg::CH_O_UP || c == crsp_pkg::CH_L_UP || c == crsp_pkg::CH_DOT ||
			c == crsp_pkg::CH_C_LO || c == crsp_pkg::CH_C_UP)
			active_items++;
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			stim_q.push_back(crsp_pkg::char_t'(s[i]));
	endtask

	// Queue a number: empty, an edge value, a plain value or a broken one
	task automatic add_number();
		int    sel;
		int    v;
		string s;
		sel = $urandom_range(0, 9);
		v = $urandom_range(0, 10 ** $urandom_range(0, 5));
		case (sel)
			0: s = "";
			1, 2: s = edge_nums[$urandom_range(0, 7)];
			8: s = $sformatf("%0d-%0d", v, $urandom_range(0, 99));
			9: s = ($urandom_range(0, 1) == 0) ? $sformatf("--%0d", v) : $sformatf("-%0d-", v);
			default: begin
				s = $sformatf("%0d", v);
				if ($urandom_range(0, 2) == 0)
					s = {"-", s};
			end
		endcase
		push_text(s);
	endtask

	// Queue one random record, a segment run or noise
	task automatic gen_record();
		int sel;
		int n;
		sel = $urandom_range(0, 39);
		if (sel < 4) begin
			n = $urandom_range(1, 6);
			repeat (n) stim_q.push_back(crsp_pkg::char_t'($urandom_range(0, 255)));
		end else if (sel == 4) begin
			n = $urandom_range(1, 140);
			repeat (n) stim_q.push_back(($urandom_range(0, 1) == 0) ?
				crsp_pkg::CH_UP : crsp_pkg::CH_DOWN);
		end else begin
			n = $urandom_range(0, 3);
			repeat (n) stim_q.push_back(($urandom_range(0, 1) == 0) ?
				crsp_pkg::CH_UP : crsp_pkg::CH_DOWN);
			add_number();
			// drop the colon now and then to repeat a close on the old x
			if ($urandom_range(0, 9) != 0)
				stim_q.push_back(crsp_pkg::CH_COLON);
			add_number();
			stim_q.push_back(crsp_pkg::CH_BANG);
			if ($urandom_range(0, 9) == 0)
				stim_q.push_back(crsp_pkg::CH_BANG);
			n = $urandom_range(0, 6);
			repeat (n) stim_q.push_back(info_set[$urandom_range(0, 4)]);
		end
	endtask

	initial begin
		sb = new();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Info and close before the first colon, saturation, info limit, repeated close
		push_text("O!99999:-99999!OLCc.C!!vv^");
		while (stim_q.size() != 0)
			send_char(stim_q.pop_front());

		while (active_items < ITEM_TARGET) begin
			gen_record();
			while (stim_q.size() != 0)
				send_char(stim_q.pop_front());
		end
		byte_valid <= 1'b0;

		// Drain, then allow for the pipeline latency
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		if (sb.errors == 0)
			$display("coordinate_record_stream_parser_tb OK");
		else
			$display("coordinate_record_stream_parser_tb NOT OK");
		$finish;
	end

endmodule

// ===== files.f =====
src/crsp_pkg.sv
src/coordinate_record_stream_parser.sv
test/coordinate_record_stream_parser_tb.sv
